>>> sv/drp_pkg.sv
// Shared types for the dense pair rank block: states, commands and status.
package drp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_PIV,
        ST_A_SCAN,
        ST_A_END,
        ST_B_RD,
        ST_B_PIV,
        ST_B_SCAN,
        ST_B_EMIT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic clr_i;
        logic inc_i;
        logic row_rd;
        logic pivot;
        logic scan;
        logic phase_b;
        logic write_first;
        logic emit;
        logic clr_count;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic scan_done;
        logic row_last;
        logic out_free;
    } status_t;

endpackage

>>> sv/pair_in_if.sv
// Input channel: one key pair word per handshake.
interface pair_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic        last_pair;

    modport source (output valid, output key_x, output key_y, output last_pair, input ready);
    modport sink (input valid, input key_x, input key_y, input last_pair, output ready);
endinterface

>>> sv/rank_out_if.sv
// Output channel: one rank word per handshake.
interface rank_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] pair_index;
    logic [5:0] dense_rank;
    logic       last_result;

    modport source (output valid, output pair_index, output dense_rank, output last_result,
                    input ready);
    modport sink (input valid, input pair_index, input dense_rank, input last_result,
                  output ready);
endinterface

>>> sv/drp_ram.sv
// Generic single write port RAM with registered read.
module drp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/drp_ctrl.sv
// Controller state machine: load, first-occurrence pass, rank pass.
module drp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  drp_pkg::status_t st,
    output drp_pkg::cmd_t    cmd
);
    import drp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (st.close) state_next = ST_A_RD;
            ST_A_RD:   state_next = ST_A_PIV;
            ST_A_PIV:  state_next = ST_A_SCAN;
            ST_A_SCAN: if (st.scan_done) state_next = ST_A_END;
            ST_A_END:  state_next = st.row_last ? ST_B_RD : ST_A_RD;
            ST_B_RD:   state_next = ST_B_PIV;
            ST_B_PIV:  state_next = ST_B_SCAN;
            ST_B_SCAN: if (st.scan_done) state_next = ST_B_EMIT;
            ST_B_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = st.row_last ? ST_IDLE : ST_B_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_en = 1'b1;
                cmd.clr_i   = 1'b1;
            end
            ST_A_RD:   cmd.row_rd = 1'b1;
            ST_A_PIV:  cmd.pivot = 1'b1;
            ST_A_SCAN: cmd.scan = 1'b1;
            ST_A_END:
            begin
                cmd.write_first = 1'b1;
                cmd.clr_i       = st.row_last;
                cmd.inc_i       = !st.row_last;
            end
            ST_B_RD:   cmd.row_rd = 1'b1;
            ST_B_PIV:  cmd.pivot = 1'b1;
            ST_B_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.phase_b = 1'b1;
            end
            ST_B_EMIT:
            begin
                cmd.emit      = st.out_free;
                cmd.clr_count = st.out_free && st.row_last;
                cmd.inc_i     = st.out_free && !st.row_last;
            end
            default:   cmd = '0;
        endcase
    end
endmodule

>>> sv/drp_dp.sv
// Datapath: key store, scan counters, compare, rank counter, output register.
module drp_dp #(
    parameter int MAX_PAIRS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  drp_pkg::cmd_t    cmd,
    output drp_pkg::status_t st,
    pair_in_if.sink          pairs,
    rank_out_if.source       ranks
);
    import drp_pkg::*;

    localparam int IW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [IW-1:0]        pj_reg, pj_next;
    logic                 pend_reg, pend_next;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        acc_reg, acc_next;
    logic [2*KW-1:0]      piv_reg, piv_next;
    logic                 ov_reg, ov_next;
    logic [5:0]           oidx_reg, oidx_next;
    logic [5:0]           orank_reg, orank_next;
    logic                 olast_reg, olast_next;

    logic                 accept;
    logic [IW-1:0]        raddr;
    logic [2*KW-1:0]      rdata;
    logic                 first_rd;
    logic                 row_last;

    assign pairs.ready = cmd.load_en;
    assign accept      = pairs.valid && cmd.load_en;
    assign row_last    = (i_reg == count_reg - CW'(1));

    assign st.close     = accept && (pairs.last_pair || count_reg == CW'(MAX_PAIRS - 1));
    assign st.scan_done = (j_reg == count_reg) && !pend_reg;
    assign st.row_last  = row_last;
    assign st.out_free  = !ov_reg || ranks.ready;

    assign raddr = cmd.row_rd ? i_reg[IW-1:0] : j_reg[IW-1:0];

    drp_ram #(.WIDTH(2 * KW), .DEPTH(MAX_PAIRS)) u_keys (
        .clk   (clk),
        .we    (accept),
        .waddr (count_reg[IW-1:0]),
        .wdata ({pairs.key_x[KW-1:0], pairs.key_y[KW-1:0]}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // First-occurrence flags, read in step with the key RAM.
    drp_ram #(.WIDTH(1), .DEPTH(MAX_PAIRS)) u_first (
        .clk   (clk),
        .we    (cmd.write_first),
        .waddr (i_reg[IW-1:0]),
        .wdata (!hit_reg),
        .raddr (raddr),
        .rdata (first_rd)
    );

    always_comb
    begin
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pj_next    = pj_reg;
        pend_next  = 1'b0;
        hit_next   = hit_reg;
        acc_next   = acc_reg;
        piv_next   = piv_reg;
        ov_next    = ov_reg && !ranks.ready;
        oidx_next  = oidx_reg;
        orank_next = orank_reg;
        olast_next = olast_reg;

        if (accept)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        if (cmd.clr_i)
        begin
            i_next = '0;
        end
        if (cmd.inc_i)
        begin
            i_next = i_reg + CW'(1);
        end
        if (cmd.row_rd)
        begin
            j_next   = '0;
            hit_next = 1'b0;
            acc_next = '0;
        end
        if (cmd.pivot)
        begin
            piv_next = rdata;
        end
        if (cmd.scan && j_reg != count_reg)
        begin
            j_next    = j_reg + CW'(1);
            pj_next   = j_reg[IW-1:0];
            pend_next = 1'b1;
        end
        if (pend_reg)
        begin
            if (cmd.phase_b)
            begin
                if (first_rd && rdata < piv_reg)
                begin
                    acc_next = acc_reg + IW'(1);
                end
            end
            else if (CW'(pj_reg) < i_reg && rdata == piv_reg)
            begin
                hit_next = 1'b1;
            end
        end
        if (cmd.emit)
        begin
            ov_next    = 1'b1;
            oidx_next  = 6'(i_reg);
            orank_next = 6'(acc_reg);
            olast_next = row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pj_reg    <= pj_next;
        hit_reg   <= hit_next;
        acc_reg   <= acc_next;
        piv_reg   <= piv_next;
        oidx_reg  <= oidx_next;
        orank_reg <= orank_next;
        olast_reg <= olast_next;
    end

    assign ranks.valid       = ov_reg;
    assign ranks.pair_index  = oidx_reg;
    assign ranks.dense_rank  = orank_reg;
    assign ranks.last_result = olast_reg;
endmodule

>>> sv/dense_rank_of_pairs.sv
// Top level of the lexicographic dense rank block.
// Pairs load one word per cycle until a word marked last arrives or the store
// of MAX_PAIRS fills. The set of n pairs is then ranked by two passes over the
// key RAM, each visiting every (i, j) combination through its single read
// port: a pass marking first occurrences of each distinct pair, then a pass
// counting the distinct pairs that order below each pair. A row of the second
// pass may wait on a result not yet taken before emitting its own; results
// leave in load order, one per row of the second pass. Input is held off from
// the closing word until the final result is registered.
module dense_rank_of_pairs #(
    parameter int MAX_PAIRS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pair_in_if.sink    pairs,
    rank_out_if.source ranks
);
    import drp_pkg::*;

    cmd_t    cmd;
    status_t st;

    drp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    drp_dp #(.MAX_PAIRS(MAX_PAIRS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .st    (st),
        .pairs (pairs),
        .ranks (ranks)
    );
endmodule

>>> dv/tb_dense_rank_of_pairs.sv
// Testbench for the dense pair rank block: directed table plus random sets, checked by a predictor.
`timescale 1ns / 1ps

module tb_dense_rank_of_pairs;

    localparam int MAX_PAIRS = 64;
    localparam int LIMIT     = 2000000;

    typedef struct {
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic        last_pair;
        bit          fixed;
        logic [5:0]  rank_fixed;
    } pair_row_t;

    typedef struct {
        logic [5:0] pair_index;
        logic [5:0] dense_rank;
        logic       last_result;
    } rank_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pair_in_if  pairs ();
    rank_out_if ranks ();

    dense_rank_of_pairs #(.MAX_PAIRS(MAX_PAIRS), .KEY_BITS(32)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pairs (pairs.sink),
        .ranks (ranks.source)
    );

    always #4 clk = ~clk;

    logic [31:0] set_x [$];
    logic [31:0] set_y [$];
    rank_word_t  pending_ranks [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    // Dense rank of each pair in the set: count distinct pairs ordering strictly below it.
    task automatic rank_set();
        int n;
        int r;
        bit dup;
        rank_word_t w;
        n = set_x.size();
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int j = 0; j < n; j++)
            begin
                if (set_x[j] < set_x[i] || (set_x[j] == set_x[i] && set_y[j] < set_y[i]))
                begin
                    dup = 1'b0;
                    for (int k = 0; k < j; k++)
                        if (set_x[k] == set_x[j] && set_y[k] == set_y[j])
                            dup = 1'b1;
                    if (!dup)
                        r++;
                end
            end
            w.pair_index  = i[5:0];
            w.dense_rank  = r[5:0];
            w.last_result = (i == n - 1);
            pending_ranks.push_back(w);
        end
        set_x.delete();
        set_y.delete();
    endtask

    task automatic send_pair(input logic [31:0] kx, input logic [31:0] ky, input logic lp);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pairs.valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        pairs.valid     <= 1'b1;
        pairs.key_x     <= kx;
        pairs.key_y     <= ky;
        pairs.last_pair <= lp;
        @(posedge clk);
        while (!pairs.ready)
            @(posedge clk);
        set_x.push_back(kx);
        set_y.push_back(ky);
        if (lp || set_x.size() == MAX_PAIRS)
            rank_set();
        @(negedge clk);
    endtask

    pair_row_t table_rows [$];
    logic [31:0] rx;
    logic [31:0] ry;
    int set_len;

    function automatic pair_row_t row(input logic [31:0] kx, input logic [31:0] ky,
                                      input logic lp, input bit fx, input logic [5:0] rf);
        pair_row_t p;
        p.key_x = kx;
        p.key_y = ky;
        p.last_pair = lp;
        p.fixed = fx;
        p.rank_fixed = rf;
        return p;
    endfunction

    initial
    begin
        pairs.valid     = 1'b0;
        pairs.key_x     = '0;
        pairs.key_y     = '0;
        pairs.last_pair = 1'b0;
        table_rows.push_back(row(32'h0, 32'h0, 1'b1, 1'b1, 6'd0));
        table_rows.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 6'd0));
        table_rows.push_back(row(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 6'd2));
        table_rows.push_back(row(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 6'd0));
        table_rows.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 6'd3));
        table_rows.push_back(row(32'hFFFF_FFFE, 32'h5, 1'b1, 1'b1, 6'd1));
        table_rows.push_back(row(32'h7, 32'h7, 1'b0, 1'b1, 6'd0));
        table_rows.push_back(row(32'h7, 32'h7, 1'b0, 1'b1, 6'd0));
        table_rows.push_back(row(32'h7, 32'h7, 1'b1, 1'b1, 6'd0));
        table_rows.push_back(row(32'h8000_0000, 32'h1, 1'b0, 1'b0, 6'd0));
        table_rows.push_back(row(32'h7FFF_FFFF, 32'h9, 1'b0, 1'b0, 6'd0));
        table_rows.push_back(row(32'h8000_0000, 32'h0, 1'b0, 1'b0, 6'd0));
        table_rows.push_back(row(32'h7FFF_FFFF, 32'h9, 1'b1, 1'b0, 6'd0));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (table_rows[t])
        begin
            send_pair(table_rows[t].key_x, table_rows[t].key_y, table_rows[t].last_pair);
            if (table_rows[t].fixed && table_rows[t].last_pair)
                foreach (pending_ranks[q])
                begin
                    int src;
                    src = t - (pending_ranks.size() - 1 - q);
                    if (pending_ranks[q].dense_rank != table_rows[src].rank_fixed)
                    begin
                        $display("table rank mismatch row %0d: expected %0d got %0d", src,
                                 table_rows[src].rank_fixed, pending_ranks[q].dense_rank);
                        mismatches++;
                    end
                end
        end
        // Full store closes a set by itself, no last marker.
        for (int i = 0; i < MAX_PAIRS; i++)
            send_pair($urandom_range(0, 9), $urandom(), 1'b0);
        for (int s = 0; s < 4; s++)
        begin
            set_len = $urandom_range(1, 10);
            if (s >= 3)
                calm = 1'b1;
            for (int i = 0; i < set_len; i++)
            begin
                case ($urandom_range(0, 2))
                    0: rx = $urandom();
                    1: rx = $urandom_range(0, 3);
                    default: rx = 32'hFFFF_FFFF - $urandom_range(0, 2);
                endcase
                ry = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2);
                send_pair(rx, ry, i == set_len - 1);
            end
        end
        pairs.valid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        ranks.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                ranks.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            ranks.ready <= 1'b1;
        end
    end

    rank_word_t exp_w;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n && ranks.valid && ranks.ready)
        begin
            if (pending_ranks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: index %0d rank %0d last %0b",
                             ranks.pair_index, ranks.dense_rank, ranks.last_result);
            end
            else
            begin
                exp_w = pending_ranks.pop_front();
                if (ranks.pair_index !== exp_w.pair_index || ranks.dense_rank !== exp_w.dense_rank
                    || ranks.last_result !== exp_w.last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 exp_w.pair_index, exp_w.dense_rank, exp_w.last_result,
                                 ranks.pair_index, ranks.dense_rank, ranks.last_result);
                end
            end
        end
    end

endmodule
